// ===== rtl/polycen_pkg.sv =====
// ----------------------------------------------------------------------------
// polycen_pkg
// Shared types, constants and the control store of the polygon centroid block.
// ----------------------------------------------------------------------------
package polycen_pkg;

  // default sizes
  localparam int DEF_COORD_BITS   = 16;
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_FRAC_BITS    = 8;

  // width of each centroid field on the result beat
  localparam int OUT_W = 24;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MS_AY_BX = 2'd0,  // (y_in - y0) * (x_prev - x0)
    MS_BY_AX = 2'd1,  // (y_prev - y0) * (x_cur - x0)
    MS_SX_F  = 2'd2,  // (x sum) * cross term
    MS_SY_F  = 2'd3   // (y sum) * cross term
  } mul_sel_t;

  // cross term register operation
  typedef enum logic [1:0] {
    F_HOLD = 2'd0,
    F_LOAD = 2'd1,
    F_SUB  = 2'd2
  } f_op_t;

  // jump conditions: taken goes to target, else to the next step
  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_ALWAYS   = 3'd1,
    J_NO_BEAT  = 3'd2,
    J_SKIP     = 3'd3,
    J_NOT_LAST = 3'd4,
    J_NO_DIV   = 3'd5,
    J_DIV_BUSY = 3'd6,
    J_OUT_BUSY = 3'd7
  } jump_t;

  // program steps
  typedef enum logic [3:0] {
    S_FETCH = 4'd0,
    S_CROSS = 4'd1,
    S_MOMX  = 4'd2,
    S_MOMY  = 4'd3,
    S_ADV   = 4'd4,
    S_TAIL  = 4'd5,
    S_PREP  = 4'd6,
    S_LOADX = 4'd7,
    S_RUNX  = 4'd8,
    S_DONEX = 4'd9,
    S_LOADY = 4'd10,
    S_RUNY  = 4'd11,
    S_DONEY = 4'd12,
    S_WAIT  = 4'd13,
    S_EMIT  = 4'd14
  } step_t;

  // one control word
  typedef struct packed {
    logic     ready;     // take an input beat
    mul_sel_t mul_sel;
    f_op_t    f_op;
    logic     prod_ld;   // register the product
    logic     area_acc;  // area += cross term
    logic     momx_acc;  // x moment += product
    logic     momy_acc;  // y moment += product
    logic     advance;   // previous <= current, count up
    logic     prep;      // classify the polygon, set up the divisor
    logic     div_load;  // load the divider with one moment
    logic     div_axis;  // 0: x, 1: y
    logic     div_step;  // one quotient bit
    logic     div_done;  // form one centroid field
    logic     emit;      // move the result to the output register
    jump_t    jump;
    step_t    target;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t uw;
    uw        = '0;
    uw.mul_sel = MS_AY_BX;
    uw.f_op   = F_HOLD;
    uw.jump   = J_NEXT;
    uw.target = S_FETCH;
    unique case (s)
      S_FETCH: begin
        uw.ready  = 1'b1;
        uw.f_op   = F_LOAD;
        uw.jump   = J_NO_BEAT;
        uw.target = S_FETCH;
      end
      S_CROSS: begin
        uw.mul_sel = MS_BY_AX;
        uw.f_op    = F_SUB;
        uw.jump    = J_SKIP;
        uw.target  = S_TAIL;
      end
      S_MOMX: begin
        uw.mul_sel  = MS_SX_F;
        uw.prod_ld  = 1'b1;
        uw.area_acc = 1'b1;
      end
      S_MOMY: begin
        uw.mul_sel  = MS_SY_F;
        uw.prod_ld  = 1'b1;
        uw.momx_acc = 1'b1;
      end
      S_ADV: begin
        uw.momy_acc = 1'b1;
        uw.advance  = 1'b1;
        uw.jump     = J_NOT_LAST;
        uw.target   = S_FETCH;
      end
      S_TAIL: begin
        uw.jump   = J_NOT_LAST;
        uw.target = S_FETCH;
      end
      S_PREP: begin
        uw.prep   = 1'b1;
        uw.jump   = J_NO_DIV;
        uw.target = S_WAIT;
      end
      S_LOADX: begin
        uw.div_load = 1'b1;
      end
      S_RUNX: begin
        uw.div_step = 1'b1;
        uw.jump     = J_DIV_BUSY;
        uw.target   = S_RUNX;
      end
      S_DONEX: begin
        uw.div_done = 1'b1;
      end
      S_LOADY: begin
        uw.div_load = 1'b1;
        uw.div_axis = 1'b1;
      end
      S_RUNY: begin
        uw.div_step = 1'b1;
        uw.div_axis = 1'b1;
        uw.jump     = J_DIV_BUSY;
        uw.target   = S_RUNY;
      end
      S_DONEY: begin
        uw.div_done = 1'b1;
        uw.div_axis = 1'b1;
      end
      S_WAIT: begin
        uw.jump   = J_OUT_BUSY;
        uw.target = S_WAIT;
      end
      S_EMIT: begin
        uw.emit   = 1'b1;
        uw.jump   = J_ALWAYS;
        uw.target = S_FETCH;
      end
      default: begin
        uw.jump   = J_ALWAYS;
        uw.target = S_FETCH;
      end
    endcase
    return uw;
  endfunction

endpackage

// ===== rtl/polygon_centroid.sv =====
// ----------------------------------------------------------------------------
// polygon_centroid
// Shoelace centroid of a polygon streamed one vertex per beat, run by a
// small microprogram over one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata (low bit up)            | tuser / tlast
//  ---------+-----------+-------------------------------+-------------------
//  in_      | sink      | point_x, point_y              | tlast = last_point
//  out_     | source    | centroid_x, centroid_y        | tuser = status
//
// A vertex runs four products on the one multiplier, the first taken during
// fetch, then an accumulate step. The first vertex and vertices past
// MAX_VERTICES run only fetch, cross term and tail.
// After the last vertex the one-bit-per-cycle divider runs once per axis.
// A zero-area or overflowed polygon skips the divider.
// Synchronous active-low reset clears the sums, the count and the sequencer.
// A result waiting in the output register stalls only the next last vertex.
//
module polygon_centroid
  import polycen_pkg::*;
#(
  parameter int COORD_BITS   = DEF_COORD_BITS,
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // point_x [COORD_BITS-1:0], point_y [2*COORD_BITS-1:COORD_BITS]
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // centroid_x [23:0], centroid_y [47:24]
  output logic [2*OUT_W-1:0]                     out_tdata,
  // status [1:0]
  output logic [1:0]                             out_tuser
);

  // derived widths
  localparam int C      = COORD_BITS;
  localparam int D_W    = C + 1;                 // coordinate difference
  localparam int S_W    = C + 2;                 // sum of two differences
  localparam int F_W    = 2 * C + 3;             // cross term
  localparam int P_W    = S_W + F_W;             // multiplier product
  localparam int LOG_V  = $clog2(MAX_VERTICES);
  localparam int AREA_W = 2 * C + 4 + LOG_V;
  localparam int MOM_W  = 3 * C + 6 + LOG_V;
  localparam int DM_W   = AREA_W + 2;            // |3 * area|
  localparam int NUM_W  = MOM_W + FRAC_BITS;     // scaled moment magnitude
  localparam int DC_W   = $clog2(NUM_W + 1);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
  localparam int O_W    = C + FRAC_BITS;         // scaled origin
  localparam int QW     = ((OUT_W > O_W) ? OUT_W : O_W) + 1;
  localparam int SUM_W  = QW + 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_OVF = CNT_W'(MAX_VERTICES + 1);

  // saturate a wide signed value to the output field
  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:OUT_W-1] == '0) || (v[SUM_W-1:OUT_W-1] == '1);
    if (fits) begin
      return v[OUT_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  // sequencer
  step_t  pc_r, pc_nxt;
  ucode_t uw;
  logic   beat;
  logic   take_jump;

  // vertex state
  logic signed [C-1:0]      in_x, in_y;
  logic signed [C-1:0]      org_x_r, org_y_r, prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic                     last_r, skip_r;
  logic [CNT_W-1:0]         cnt_r;

  // arithmetic
  logic signed [D_W-1:0]    ay_in, ax, ay, bx, by;
  logic signed [S_W-1:0]    sx, sy;
  logic signed [S_W-1:0]    mul_a;
  logic signed [F_W-1:0]    mul_b;
  logic signed [P_W-1:0]    mul_p;
  logic signed [F_W-1:0]    f_r;
  logic signed [P_W-1:0]    prod_r;
  logic signed [AREA_W-1:0] area_r;
  logic signed [MOM_W-1:0]  mom_x_r, mom_y_r;

  // finish and divider
  logic                     overflow, no_div;
  logic [AREA_W-1:0]        area_mag;
  logic [DM_W-1:0]          dm_calc, dm_r;
  logic signed [MOM_W-1:0]  mom_sel;
  logic [MOM_W-1:0]         mom_mag;
  logic [NUM_W-1:0]         num_r;
  logic [DM_W-1:0]          rem_r;
  logic [DM_W:0]            trial, trial_diff;
  logic                     q_bit;
  logic [QW-1:0]            quo_r, qmag;
  logic                     big_r, neg_r;
  logic [DC_W-1:0]          dcnt_r;
  logic signed [O_W-1:0]    o_x, o_y, o_sel;
  logic signed [SUM_W-1:0]  q_signed, fix_sum;
  logic signed [OUT_W-1:0]  res_x_r, res_y_r;
  status_t                  status_r;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]  out_x_r, out_y_r;
  status_t                  out_st_r;
  logic                     out_busy;

  // control word of the current step
  assign uw        = ucode_rom(pc_r);
  assign in_tready = uw.ready;
  assign beat      = in_tvalid & in_tready;
  assign out_busy  = out_valid_r & ~out_tready;

  // input fields
  assign in_x = in_tdata[C-1:0];
  assign in_y = in_tdata[2*C-1:C];

  // coordinate differences taken from the first vertex
  assign ay_in = D_W'(in_y) - D_W'(org_y_r);
  assign ax    = D_W'(cur_x_r) - D_W'(org_x_r);
  assign ay    = D_W'(cur_y_r) - D_W'(org_y_r);
  assign bx    = D_W'(prev_x_r) - D_W'(org_x_r);
  assign by    = D_W'(prev_y_r) - D_W'(org_y_r);
  assign sx    = S_W'(ax) + S_W'(bx);
  assign sy    = S_W'(ay) + S_W'(by);

  // shared multiplier operand select
  always_comb begin
    case (uw.mul_sel)
      MS_AY_BX: begin
        mul_a = S_W'(ay_in);
        mul_b = F_W'(bx);
      end
      MS_BY_AX: begin
        mul_a = S_W'(by);
        mul_b = F_W'(ax);
      end
      MS_SX_F: begin
        mul_a = sx;
        mul_b = f_r;
      end
      default: begin
        mul_a = sy;
        mul_b = f_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // polygon classification at the finish
  assign overflow = cnt_r > CNT_MAX;
  assign no_div   = overflow || (area_r == '0);
  assign area_mag = area_r[AREA_W-1] ? AREA_W'(-area_r) : AREA_W'(area_r);
  assign dm_calc  = {1'b0, area_mag, 1'b0} + {2'b00, area_mag};

  // divider operand and one restoring step
  assign mom_sel    = uw.div_axis ? mom_y_r : mom_x_r;
  assign mom_mag    = mom_sel[MOM_W-1] ? MOM_W'(-mom_sel) : MOM_W'(mom_sel);
  assign trial      = {rem_r, num_r[NUM_W-1]};
  assign trial_diff = trial - {1'b0, dm_r};
  assign q_bit      = trial >= {1'b0, dm_r};

  // signed quotient plus scaled origin
  assign o_x      = O_W'(org_x_r) <<< FRAC_BITS;
  assign o_y      = O_W'(org_y_r) <<< FRAC_BITS;
  assign o_sel    = uw.div_axis ? o_y : o_x;
  assign qmag     = big_r ? '1 : quo_r;
  assign q_signed = neg_r ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
  assign fix_sum  = q_signed + SUM_W'(o_sel);

  // jump condition
  always_comb begin
    case (uw.jump)
      J_NEXT:     take_jump = 1'b0;
      J_ALWAYS:   take_jump = 1'b1;
      J_NO_BEAT:  take_jump = ~beat;
      J_SKIP:     take_jump = skip_r;
      J_NOT_LAST: take_jump = ~last_r;
      J_NO_DIV:   take_jump = no_div;
      J_DIV_BUSY: take_jump = dcnt_r > DC_W'(1);
      default:    take_jump = out_busy;
    endcase
  end

  // next step
  always_comb begin
    if (take_jump) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = step_t'(pc_r + 1'b1);
    end
  end

  // output valid
  always_comb begin
    if (uw.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_busy;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // vertex count and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      area_r  <= '0;
      mom_x_r <= '0;
      mom_y_r <= '0;
    end else begin
      if (beat) begin
        if (cnt_r == '0) begin
          cnt_r <= CNT_W'(1);
        end else if (cnt_r >= CNT_MAX) begin
          cnt_r <= CNT_OVF;
        end
      end
      if (uw.advance) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (uw.area_acc) begin
        area_r <= area_r + AREA_W'(f_r);
      end
      if (uw.momx_acc) begin
        mom_x_r <= mom_x_r + MOM_W'(prod_r);
      end
      if (uw.momy_acc) begin
        mom_y_r <= mom_y_r + MOM_W'(prod_r);
      end
      // a delivered polygon starts the next one from scratch
      if (uw.emit) begin
        cnt_r   <= '0;
        area_r  <= '0;
        mom_x_r <= '0;
        mom_y_r <= '0;
      end
    end
  end

  // vertex latch, cross term and product
  always_ff @(posedge clk) begin
    if (beat) begin
      cur_x_r <= in_x;
      cur_y_r <= in_y;
      last_r  <= in_tlast;
      skip_r  <= (cnt_r == '0) || (cnt_r >= CNT_MAX);
      if (cnt_r == '0) begin
        org_x_r  <= in_x;
        org_y_r  <= in_y;
        prev_x_r <= in_x;
        prev_y_r <= in_y;
      end
    end
    if (uw.advance) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    case (uw.f_op)
      F_LOAD:  f_r <= mul_p[F_W-1:0];
      F_SUB:   f_r <= f_r - mul_p[F_W-1:0];
      default: f_r <= f_r;
    endcase
    if (uw.prod_ld) begin
      prod_r <= mul_p;
    end
  end

  // finish: status, divisor, bit-serial division and result fields
  always_ff @(posedge clk) begin
    if (uw.prep) begin
      dm_r <= dm_calc;
      if (overflow) begin
        res_x_r  <= '0;
        res_y_r  <= '0;
        status_r <= ST_OVERFLOW;
      end else if (area_r == '0) begin
        res_x_r  <= sat_out(SUM_W'(o_x));
        res_y_r  <= sat_out(SUM_W'(o_y));
        status_r <= ST_DEGEN;
      end else begin
        status_r <= ST_OK;
      end
    end
    if (uw.div_load) begin
      num_r  <= NUM_W'(mom_mag) << FRAC_BITS;
      neg_r  <= mom_sel[MOM_W-1] ^ area_r[AREA_W-1];
      rem_r  <= '0;
      quo_r  <= '0;
      big_r  <= 1'b0;
      dcnt_r <= DC_W'(NUM_W);
    end
    if (uw.div_step) begin
      rem_r  <= q_bit ? trial_diff[DM_W-1:0] : trial[DM_W-1:0];
      num_r  <= num_r << 1;
      quo_r  <= {quo_r[QW-2:0], q_bit};
      big_r  <= big_r | quo_r[QW-1];
      dcnt_r <= dcnt_r - DC_W'(1);
    end
    if (uw.div_done) begin
      if (uw.div_axis) begin
        res_y_r <= sat_out(fix_sum);
      end else begin
        res_x_r <= sat_out(fix_sum);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (uw.emit) begin
      out_x_r  <= res_x_r;
      out_y_r  <= res_y_r;
      out_st_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_st_r;

  // a result appears only out of the emit step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == S_EMIT)
    else $error("result raised outside the emit step");

  // an overflowed polygon carries zero centroid fields
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_OVERFLOW) |-> out_tdata == '0)
    else $error("overflow result with nonzero centroid");

  // emitting a result clears the polygon state
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_EMIT) |=> (cnt_r == '0 && area_r == '0))
    else $error("polygon state not cleared after emit");

  // the vertex count saturates one past the limit
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_OVF)
    else $error("vertex count beyond saturation");

  // the divider never steps with an empty bit count
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_RUNX || pc_r == S_RUNY) |-> dcnt_r != '0)
    else $error("divider stepped past its last bit");

endmodule
